// ===== rtl/klep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klep_pkg
// Shared types and fixed field widths for the keyed LRU entry pool.
// ----------------------------------------------------------------------------
package klep_pkg;

    localparam int KEY_W  = 24;
    localparam int SLOT_W = 6;
    localparam int RCNT_W = 7;
    localparam logic [RCNT_W-1:0] RCNT_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_LOOKUP      = 2'd0,
        OP_ALLOC       = 2'd1,
        OP_REMOVE      = 2'd2,
        OP_REMOVE_USER = 2'd3
    } opcode_t;

    // scan control from the sequencer
    typedef struct packed {
        logic start;      // clear gathered results
        logic sample;     // read data of one slot is present
        logic user_only;  // match on user key alone
    } scan_ctl_t;

    // scan status back to the sequencer
    typedef struct packed {
        logic match;
        logic free_found;
        logic old_found;
    } scan_stat_t;

endpackage

// ===== rtl/klep_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klep_req_if
// Request channel: opcode and key pair, valid/ready handshake.
// ----------------------------------------------------------------------------
interface klep_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [klep_pkg::KEY_W-1:0] user_key;
    logic [klep_pkg::KEY_W-1:0] contest_key;

    modport source (output valid, output opcode, output user_key, output contest_key,
                    input ready);
    modport sink   (input valid, input opcode, input user_key, input contest_key,
                    output ready);
endinterface

// ===== rtl/klep_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klep_rsp_if
// Response channel: hit, slot handle, eviction and removal report.
// ----------------------------------------------------------------------------
interface klep_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [klep_pkg::SLOT_W-1:0] slot;
    logic                        slot_valid;
    logic                        evicted;
    logic [klep_pkg::KEY_W-1:0]  evicted_user;
    logic [klep_pkg::KEY_W-1:0]  evicted_contest;
    logic [klep_pkg::RCNT_W-1:0] removed_count;

    modport source (output valid, output hit, output slot, output slot_valid,
                    output evicted, output evicted_user, output evicted_contest,
                    output removed_count, input ready);
    modport sink   (input valid, input hit, input slot, input slot_valid,
                    input evicted, input evicted_user, input evicted_contest,
                    input removed_count, output ready);
endinterface

// ===== rtl/klep_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klep_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module klep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/klep_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// klep_scan
// Gathers, one slot per cycle, the first key match, the lowest free slot
// and the least recent entry.
// ----------------------------------------------------------------------------
module klep_scan #(
    parameter int IW = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  klep_pkg::scan_ctl_t       ctl,
    input  logic [klep_pkg::KEY_W-1:0] key_user,
    input  logic [klep_pkg::KEY_W-1:0] key_contest,
    input  logic [IW-1:0]             old_age,
    input  logic [IW-1:0]             rd_idx,
    input  logic                      rd_valid,
    input  logic [klep_pkg::KEY_W-1:0] rd_user,
    input  logic [klep_pkg::KEY_W-1:0] rd_contest,
    input  logic [IW-1:0]             rd_age,
    output klep_pkg::scan_stat_t      stat,
    output logic [IW-1:0]             match_idx,
    output logic [IW-1:0]             match_age,
    output logic [IW-1:0]             free_idx,
    output logic [IW-1:0]             old_idx,
    output logic [klep_pkg::KEY_W-1:0] old_user,
    output logic [klep_pkg::KEY_W-1:0] old_contest
);

    import klep_pkg::*;

    scan_stat_t      stat_reg;
    logic [IW-1:0]   match_idx_reg;
    logic [IW-1:0]   match_age_reg;
    logic [IW-1:0]   free_idx_reg;
    logic [IW-1:0]   old_idx_reg;
    logic [KEY_W-1:0] old_user_reg;
    logic [KEY_W-1:0] old_contest_reg;
    logic            is_match;
    logic            is_old;

    assign is_match = rd_valid && (rd_user == key_user)
                      && (ctl.user_only || (rd_contest == key_contest));
    // ages are distinct, so the least recent entry carries age total-1
    assign is_old   = rd_valid && (rd_age == old_age);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else if (ctl.start)
        begin
            stat_reg <= '0;
        end
        else if (ctl.sample)
        begin
            if (is_match)
            begin
                stat_reg.match <= 1'b1;
            end
            if (!rd_valid)
            begin
                stat_reg.free_found <= 1'b1;
            end
            if (is_old)
            begin
                stat_reg.old_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sample)
        begin
            if (is_match && !stat_reg.match)
            begin
                match_idx_reg <= rd_idx;
                match_age_reg <= rd_age;
            end
            if (!rd_valid && !stat_reg.free_found)
            begin
                free_idx_reg <= rd_idx;
            end
            if (is_old && !stat_reg.old_found)
            begin
                old_idx_reg     <= rd_idx;
                old_user_reg    <= rd_user;
                old_contest_reg <= rd_contest;
            end
        end
    end

    assign stat        = stat_reg;
    assign match_idx   = match_idx_reg;
    assign match_age   = match_age_reg;
    assign free_idx    = free_idx_reg;
    assign old_idx     = old_idx_reg;
    assign old_user    = old_user_reg;
    assign old_contest = old_contest_reg;

endmodule

// ===== rtl/keyed_lru_entry_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_lru_entry_pool
// Fully associative LRU pool of key pairs, held in one slot memory.
// A lookup or remove that misses ends after the scan pass; a remove-user runs
//   one scan and one update pass per entry it drops, then a final scan. A zero
//   user key, or a zero contest key on a lookup or remove, skips both passes.
// Throughput: one request at a time; ready returns as the response is loaded.
//   Each pass reads one slot per cycle (scan pass, then a read-modify-write
//   pass); a response still held at the output stalls the final step.
// Reset: clears control state, then sweeps every slot to empty the
//   slot memory before the first request is taken.
// ----------------------------------------------------------------------------
module keyed_lru_entry_pool #(
    parameter int POOL_SLOTS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    klep_req_if.sink   req,
    klep_rsp_if.source rsp
);

    import klep_pkg::*;

    localparam int IW     = $clog2(POOL_SLOTS);
    localparam int TW     = $clog2(POOL_SLOTS + 1);
    localparam int WORD_W = 1 + 2 * KEY_W + IW;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_UPDATE = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        UPD_TOUCH   = 3'b001,
        UPD_AGE_ALL = 3'b010,
        UPD_DROP    = 3'b100
    } upd_kind_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic              iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    logic [TW-1:0]     total_reg, total_next;
    opcode_t           op_reg, op_next;
    logic [KEY_W-1:0]  user_reg, user_next;
    logic [KEY_W-1:0]  contest_reg, contest_next;
    upd_kind_t         upd_reg, upd_next;
    logic [IW-1:0]     tgt_idx_reg, tgt_idx_next;
    logic [IW-1:0]     tgt_age_reg, tgt_age_next;

    logic              res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_sv_reg, res_sv_next;
    logic              res_ev_reg, res_ev_next;
    logic [KEY_W-1:0]  res_eu_reg, res_eu_next;
    logic [KEY_W-1:0]  res_ec_reg, res_ec_next;
    logic [RCNT_W-1:0] rc_reg, rc_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_sv_reg;
    logic              out_ev_reg;
    logic [KEY_W-1:0]  out_eu_reg;
    logic [KEY_W-1:0]  out_ec_reg;
    logic [RCNT_W-1:0] out_rc_reg;
    logic              out_load;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    logic              rd_valid;
    logic [KEY_W-1:0]  rd_user;
    logic [KEY_W-1:0]  rd_contest;
    logic [IW-1:0]     rd_age;
    logic              w_valid;
    logic [KEY_W-1:0]  w_user;
    logic [KEY_W-1:0]  w_contest;
    logic [IW-1:0]     w_age;
    logic [WORD_W-1:0] upd_word;

    scan_ctl_t         ctl;
    scan_stat_t        stat;
    logic [IW-1:0]     match_idx;
    logic [IW-1:0]     match_age;
    logic [IW-1:0]     free_idx;
    logic [IW-1:0]     old_idx;
    logic [KEY_W-1:0]  old_user;
    logic [KEY_W-1:0]  old_contest;
    logic [TW-1:0]     old_age_full;

    logic              cnt_last;
    logic              pool_full;
    logic              req_null;
    logic [IW-1:0]     slot_sel;
    logic [SLOT_W+IW-1:0] slot_ext;

    klep_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POOL_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign {rd_valid, rd_user, rd_contest, rd_age} = ram_rdata;
    assign old_age_full = total_reg - TW'(1);

    klep_scan #(
        .IW (IW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .key_user    (user_reg),
        .key_contest (contest_reg),
        .old_age     (old_age_full[IW-1:0]),
        .rd_idx      (pend_idx_reg),
        .rd_valid    (rd_valid),
        .rd_user     (rd_user),
        .rd_contest  (rd_contest),
        .rd_age      (rd_age),
        .stat        (stat),
        .match_idx   (match_idx),
        .match_age   (match_age),
        .free_idx    (free_idx),
        .old_idx     (old_idx),
        .old_user    (old_user),
        .old_contest (old_contest)
    );

    assign cnt_last  = (cnt_reg == IW'(POOL_SLOTS - 1));
    assign pool_full = (total_reg == TW'(POOL_SLOTS));
    assign req_null  = (req.user_key == '0)
                       || ((req.contest_key == '0)
                           && ((opcode_t'(req.opcode) == OP_LOOKUP)
                               || (opcode_t'(req.opcode) == OP_REMOVE)));

    // write-back word for the read-modify-write pass
    always_comb
    begin
        w_valid   = rd_valid;
        w_user    = rd_user;
        w_contest = rd_contest;
        w_age     = rd_age;
        if (pend_idx_reg == tgt_idx_reg)
        begin
            case (upd_reg)
                UPD_TOUCH:
                begin
                    w_age = '0;
                end
                UPD_AGE_ALL:
                begin
                    w_valid   = 1'b1;
                    w_user    = user_reg;
                    w_contest = contest_reg;
                    w_age     = '0;
                end
                UPD_DROP:
                begin
                    w_valid = 1'b0;
                end
                default:
                begin
                    w_valid = rd_valid;
                end
            endcase
        end
        else if (rd_valid)
        begin
            case (upd_reg)
                UPD_TOUCH:
                begin
                    if (rd_age < tgt_age_reg)
                    begin
                        w_age = rd_age + IW'(1);
                    end
                end
                UPD_AGE_ALL:
                begin
                    w_age = rd_age + IW'(1);
                end
                UPD_DROP:
                begin
                    if (rd_age > tgt_age_reg)
                    begin
                        w_age = rd_age - IW'(1);
                    end
                end
                default:
                begin
                    w_age = rd_age;
                end
            endcase
        end
        upd_word = {w_valid, w_user, w_contest, w_age};
    end

    // slot handle of the decided entry, reported modulo 64
    always_comb
    begin
        slot_sel = match_idx;
        if ((op_reg == OP_ALLOC) && !stat.match)
        begin
            slot_sel = pool_full ? old_idx : free_idx;
        end
        slot_ext = {{SLOT_W{1'b0}}, slot_sel};
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        pend_next     = 1'b0;
        pend_idx_next = cnt_reg;
        total_next    = total_reg;
        op_next       = op_reg;
        user_next     = user_reg;
        contest_next  = contest_reg;
        upd_next      = upd_reg;
        tgt_idx_next  = tgt_idx_reg;
        tgt_age_next  = tgt_age_reg;
        res_hit_next  = res_hit_reg;
        res_slot_next = res_slot_reg;
        res_sv_next   = res_sv_reg;
        res_ev_next   = res_ev_reg;
        res_eu_next   = res_eu_reg;
        res_ec_next   = res_ec_reg;
        rc_next       = rc_reg;
        out_load      = 1'b0;
        ctl.start     = 1'b0;
        ctl.sample    = 1'b0;
        ctl.user_only = (op_reg == OP_REMOVE_USER);
        ram_we        = 1'b0;
        ram_waddr     = pend_idx_reg;
        ram_wdata     = upd_word;

        // shared read issue for both passes
        if (((state_reg == S_SCAN) || (state_reg == S_UPDATE)) && iss_reg)
        begin
            pend_next     = 1'b1;
            pend_idx_next = cnt_reg;
            if (cnt_last)
            begin
                iss_next = 1'b0;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + IW'(1);
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                if (cnt_last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = opcode_t'(req.opcode);
                    user_next     = req.user_key;
                    contest_next  = req.contest_key;
                    res_hit_next  = 1'b0;
                    res_slot_next = '0;
                    res_sv_next   = 1'b0;
                    res_ev_next   = 1'b0;
                    res_eu_next   = '0;
                    res_ec_next   = '0;
                    rc_next       = '0;
                    cnt_next      = '0;
                    if (req_null)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.start  = 1'b1;
                        iss_next   = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ctl.sample = pend_reg;
                // once the last sample has been registered the scan results are settled
                if (!iss_reg && !pend_reg)
                begin
                    iss_next   = 1'b1;
                    state_next = S_UPDATE;
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            upd_next     = UPD_TOUCH;
                            tgt_idx_next = match_idx;
                            tgt_age_next = match_age;
                            if (stat.match)
                            begin
                                res_hit_next  = 1'b1;
                                res_slot_next = slot_ext[SLOT_W-1:0];
                                res_sv_next   = 1'b1;
                            end
                            else
                            begin
                                iss_next   = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        OP_ALLOC:
                        begin
                            res_slot_next = slot_ext[SLOT_W-1:0];
                            res_sv_next   = 1'b1;
                            if (stat.match)
                            begin
                                upd_next     = UPD_TOUCH;
                                tgt_idx_next = match_idx;
                                tgt_age_next = match_age;
                                res_hit_next = 1'b1;
                            end
                            else if (pool_full)
                            begin
                                // evict least recent, new entry takes its slot
                                upd_next     = UPD_AGE_ALL;
                                tgt_idx_next = old_idx;
                                res_ev_next  = 1'b1;
                                res_eu_next  = old_user;
                                res_ec_next  = old_contest;
                            end
                            else
                            begin
                                upd_next     = UPD_AGE_ALL;
                                tgt_idx_next = free_idx;
                                total_next   = total_reg + TW'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            upd_next     = UPD_DROP;
                            tgt_idx_next = match_idx;
                            tgt_age_next = match_age;
                            if (stat.match)
                            begin
                                res_hit_next = 1'b1;
                                rc_next      = RCNT_W'(1);
                                total_next   = total_reg - TW'(1);
                            end
                            else
                            begin
                                iss_next   = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        OP_REMOVE_USER:
                        begin
                            upd_next     = UPD_DROP;
                            tgt_idx_next = match_idx;
                            tgt_age_next = match_age;
                            if (stat.match)
                            begin
                                total_next = total_reg - TW'(1);
                                if (rc_reg != RCNT_MAX)
                                begin
                                    rc_next = rc_reg + RCNT_W'(1);
                                end
                            end
                            else
                            begin
                                iss_next   = 1'b0;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            iss_next   = 1'b0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_UPDATE:
            begin
                ram_we = pend_reg;
                if (pend_reg && !iss_reg)
                begin
                    if (op_reg == OP_REMOVE_USER)
                    begin
                        // drop one user entry per round, then search again
                        ctl.start  = 1'b1;
                        iss_next   = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            iss_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        op_reg       <= op_next;
        user_reg     <= user_next;
        contest_reg  <= contest_next;
        upd_reg      <= upd_next;
        tgt_idx_reg  <= tgt_idx_next;
        tgt_age_reg  <= tgt_age_next;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        res_sv_reg   <= res_sv_next;
        res_ev_reg   <= res_ev_next;
        res_eu_reg   <= res_eu_next;
        res_ec_reg   <= res_ec_next;
        rc_reg       <= rc_next;
        if (out_load)
        begin
            out_hit_reg  <= res_hit_reg;
            out_slot_reg <= res_slot_reg;
            out_sv_reg   <= res_sv_reg;
            out_ev_reg   <= res_ev_reg;
            out_eu_reg   <= res_eu_reg;
            out_ec_reg   <= res_ec_reg;
            out_rc_reg   <= rc_reg;
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.hit             = out_hit_reg;
    assign rsp.slot            = out_slot_reg;
    assign rsp.slot_valid      = out_sv_reg;
    assign rsp.evicted         = out_ev_reg;
    assign rsp.evicted_user    = out_eu_reg;
    assign rsp.evicted_contest = out_ec_reg;
    assign rsp.removed_count   = out_rc_reg;

endmodule

// ===== tb/keyed_lru_entry_pool_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_lru_entry_pool_tb
// Self-checking bench for the keyed LRU pool. Requests come from a queue that
// is filled up front: a directed opening, then random traffic over a small set
// of hot keys so that hits, evictions and user sweeps happen often. A
// predictor tracks slots and ages and works out each response. The monitor
// checks each response field by field, in order.
// ----------------------------------------------------------------------------
module keyed_lru_entry_pool_tb;

    import klep_pkg::*;

    localparam int POOL_N       = 64;
    localparam int RANDOM_ITEMS = 1880;
    localparam int TAIL_ITEMS   = 150;
    localparam int LONG_HOLD_AT = 400;
    localparam int LONG_HOLD    = 800;
    localparam int TAIL_CYCLES  = 2 * POOL_N + 40;
    localparam int WATCHDOG_MAX = 40000;

    typedef struct packed {
        opcode_t          op;
        logic [KEY_W-1:0] user;
        logic [KEY_W-1:0] contest;
        logic             drain_first;   // hold off until every response is back
    } pool_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              slot_valid;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_user;
        logic [KEY_W-1:0]  evicted_contest;
        logic [RCNT_W-1:0] removed_count;
    } pool_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    klep_req_if req_bus ();
    klep_rsp_if rsp_bus ();

    keyed_lru_entry_pool #(
        .POOL_SLOTS (POOL_N)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #2 clk = ~clk;

    // shadow of the pool
    logic             slot_used    [POOL_N];
    logic [KEY_W-1:0] slot_user    [POOL_N];
    logic [KEY_W-1:0] slot_contest [POOL_N];
    int unsigned      slot_age     [POOL_N];
    int unsigned      used_count;

    pool_req_t pending_reqs[$];
    pool_rsp_t pool_results_due[$];
    pool_req_t next_req;
    pool_req_t taken_req;
    pool_rsp_t want_rsp;

    int num_items;
    int reqs_taken;
    int outstanding;
    int results_seen = 0;
    int fail_count = 0;
    int send_gap;
    int stall_left;
    bit long_hold_done;
    int idle_cycles = 0;

    logic [KEY_W-1:0] hot_users    [6];
    logic [KEY_W-1:0] hot_contests [16];

    function automatic int find_entry(logic [KEY_W-1:0] u, logic [KEY_W-1:0] c);
        for (int i = 0; i < POOL_N; i++)
            if (slot_used[i] && slot_user[i] == u && slot_contest[i] == c)
                return i;
        return -1;
    endfunction

    function automatic void make_newest(int s);
        int unsigned a;
        a = slot_age[s];
        for (int i = 0; i < POOL_N; i++)
            if (slot_used[i] && slot_age[i] < a)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic void free_entry(int s);
        int unsigned a;
        a = slot_age[s];
        slot_used[s] = 1'b0;
        for (int i = 0; i < POOL_N; i++)
            if (slot_used[i] && slot_age[i] > a)
                slot_age[i]--;
        if (used_count > 0)
            used_count--;
    endfunction

    function automatic pool_rsp_t lru_outcome(pool_req_t r);
        pool_rsp_t o;
        int s;
        int oldest;
        o = '0;
        if (r.user == '0)
            return o;
        case (r.op)
            OP_LOOKUP, OP_ALLOC:
            begin
                s = (r.contest != '0 || r.op == OP_ALLOC) ? find_entry(r.user, r.contest) : -1;
                if (s >= 0)
                begin
                    make_newest(s);
                    o.hit        = 1'b1;
                    o.slot       = s[SLOT_W-1:0];
                    o.slot_valid = 1'b1;
                end
                else if (r.op == OP_ALLOC)
                begin
                    if (used_count >= POOL_N)
                    begin
                        oldest = -1;
                        for (int i = 0; i < POOL_N; i++)
                            if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                                oldest = i;
                        if (oldest >= 0)
                        begin
                            o.evicted         = 1'b1;
                            o.evicted_user    = slot_user[oldest];
                            o.evicted_contest = slot_contest[oldest];
                            free_entry(oldest);
                        end
                    end
                    s = -1;
                    for (int i = 0; i < POOL_N; i++)
                        if (!slot_used[i])
                        begin
                            s = i;
                            break;
                        end
                    if (s >= 0)
                    begin
                        for (int i = 0; i < POOL_N; i++)
                            if (slot_used[i])
                                slot_age[i]++;
                        slot_used[s]    = 1'b1;
                        slot_user[s]    = r.user;
                        slot_contest[s] = r.contest;
                        slot_age[s]     = 0;
                        used_count++;
                        o.slot       = s[SLOT_W-1:0];
                        o.slot_valid = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                s = (r.contest != '0) ? find_entry(r.user, r.contest) : -1;
                if (s >= 0)
                begin
                    free_entry(s);
                    o.hit           = 1'b1;
                    o.removed_count = RCNT_W'(1);
                end
            end
            default:
            begin
                for (int i = 0; i < POOL_N; i++)
                    if (slot_used[i] && slot_user[i] == r.user)
                    begin
                        free_entry(i);
                        if (o.removed_count < RCNT_MAX)
                            o.removed_count++;
                    end
            end
        endcase
        return o;
    endfunction

    task automatic check_field(string fname, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("response %0d: %s expected %0h, got %0h", results_seen, fname, want, got);
        end
    endtask

    function automatic void add_req(opcode_t op, logic [KEY_W-1:0] u, logic [KEY_W-1:0] c,
                                    bit drain = 1'b0);
        pool_req_t r;
        r.op          = op;
        r.user        = u;
        r.contest     = c;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [KEY_W-1:0] pick_user(bit wide_phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return KEY_W'($urandom());
        if (r < 6)
            return '0;
        return wide_phase ? hot_users[$urandom_range(0, 2)] : hot_users[$urandom_range(0, 5)];
    endfunction

    function automatic logic [KEY_W-1:0] pick_contest(bit wide_phase);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 8)
            return KEY_W'($urandom());
        return wide_phase ? KEY_W'($urandom_range(1, 40)) : hot_contests[$urandom_range(0, 15)];
    endfunction

    function automatic opcode_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return OP_LOOKUP;
        if (r < 80)
            return OP_ALLOC;
        if (r < 95)
            return OP_REMOVE;
        return OP_REMOVE_USER;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid       <= 1'b0;
            req_bus.opcode      <= OP_LOOKUP;
            req_bus.user_key    <= '0;
            req_bus.contest_key <= '0;
            send_gap            <= 0;
        end
        else if (!req_bus.valid || req_bus.ready)
        begin
            if (send_gap != 0)
            begin
                send_gap      <= send_gap - 1;
                req_bus.valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && (outstanding != 0 || req_bus.valid)))
            begin
                req_bus.valid <= 1'b0;
            end
            else
            begin
                next_req = pending_reqs.pop_front();
                req_bus.valid       <= 1'b1;
                req_bus.opcode      <= next_req.op;
                req_bus.user_key    <= next_req.user;
                req_bus.contest_key <= next_req.contest;
                if (reqs_taken < num_items - TAIL_ITEMS && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 16);
            end
        end
    end

    // response ready, with short random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready  <= 1'b0;
            stall_left     <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && reqs_taken >= LONG_HOLD_AT)
        begin
            long_hold_done <= 1'b1;
            stall_left     <= LONG_HOLD - 1;
            rsp_bus.ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else if (reqs_taken < num_items - TAIL_ITEMS && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 15);
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // monitor: predict on request, check on response
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < POOL_N; i++)
            begin
                slot_used[i]    = 1'b0;
                slot_user[i]    = '0;
                slot_contest[i] = '0;
                slot_age[i]     = 0;
            end
            used_count = 0;
            pool_results_due.delete();
            reqs_taken  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                taken_req.op          = opcode_t'(req_bus.opcode);
                taken_req.user        = req_bus.user_key;
                taken_req.contest     = req_bus.contest_key;
                taken_req.drain_first = 1'b0;
                pool_results_due.push_back(lru_outcome(taken_req));
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (pool_results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("response %0d arrived with no request outstanding",
                                 results_seen);
                end
                else
                begin
                    want_rsp = pool_results_due.pop_front();
                    check_field("hit", KEY_W'(want_rsp.hit), KEY_W'(rsp_bus.hit));
                    check_field("slot", KEY_W'(want_rsp.slot), KEY_W'(rsp_bus.slot));
                    check_field("slot_valid", KEY_W'(want_rsp.slot_valid),
                                KEY_W'(rsp_bus.slot_valid));
                    check_field("evicted", KEY_W'(want_rsp.evicted), KEY_W'(rsp_bus.evicted));
                    check_field("evicted_user", want_rsp.evicted_user, rsp_bus.evicted_user);
                    check_field("evicted_contest", want_rsp.evicted_contest,
                                rsp_bus.evicted_contest);
                    check_field("removed_count", KEY_W'(want_rsp.removed_count),
                                KEY_W'(rsp_bus.removed_count));
                end
                results_seen++;
            end
            reqs_taken  <= reqs_taken + (req_bus.valid && req_bus.ready);
            outstanding <= outstanding + (req_bus.valid && req_bus.ready)
                           - (rsp_bus.valid && rsp_bus.ready && outstanding != 0);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("keyed_lru_entry_pool verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        num_items           = 1 << 30;

        hot_users[0] = 1;
        hot_users[1] = 2;
        hot_users[2] = 24'hFFFFFF;
        hot_users[3] = 3;
        hot_users[4] = KEY_W'($urandom_range(1, 24'hFFFFFF));
        hot_users[5] = KEY_W'($urandom_range(1, 24'hFFFFFF));
        for (int i = 0; i < 13; i++)
            hot_contests[i] = KEY_W'(i + 1);
        hot_contests[13] = 24'hFFFFFF;
        hot_contests[14] = KEY_W'($urandom_range(1, 24'hFFFFFF));
        hot_contests[15] = KEY_W'($urandom_range(1, 24'hFFFFFF));

        // directed opening
        add_req(OP_LOOKUP, 1, 1);                       // empty pool miss
        add_req(OP_ALLOC, 1, 1);
        add_req(OP_ALLOC, 24'hFFFFFF, 24'hFFFFFF);
        add_req(OP_LOOKUP, 1, 1);
        add_req(OP_LOOKUP, 1, 0);                       // zero contest never hits
        add_req(OP_ALLOC, 1, 0);                        // allocate takes zero contest
        add_req(OP_REMOVE, 1, 0);                       // ... but remove cannot reach it
        add_req(OP_LOOKUP, 24'hFFFFFF, 24'hFFFFFF);
        add_req(OP_ALLOC, 1, 1);                        // reuse on hit
        add_req(OP_REMOVE, 24'hFFFFFF, 24'hFFFFFF);
        add_req(OP_REMOVE, 24'hFFFFFF, 24'hFFFFFF);
        add_req(OP_LOOKUP, 0, 1);                       // zero user: all-zero result
        add_req(OP_ALLOC, 0, 1);
        add_req(OP_REMOVE, 0, 1);
        add_req(OP_REMOVE_USER, 0, 0);
        add_req(OP_ALLOC, 1, 24'hA5A5A5);
        add_req(OP_ALLOC, 24'h5A5A5A, 1);
        add_req(OP_REMOVE_USER, 1, 24'hFFFFFF);         // contest ignored
        add_req(OP_REMOVE_USER, 1, 0);
        add_req(OP_ALLOC, 24'hFFFFFF, 1);               // lowest free slot
        add_req(OP_LOOKUP, 24'h5A5A5A, 1);
        add_req(OP_REMOVE_USER, 24'h5A5A5A, 24'h123456);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 1500)
            begin
                // one user fills and then overflows the pool, then is swept out
                for (int k = 0; k < POOL_N + 6; k++)
                    add_req(OP_ALLOC, hot_users[0], KEY_W'(100 + k));
                add_req(OP_REMOVE_USER, hot_users[0], KEY_W'($urandom()));
                n += POOL_N + 7;
            end
            add_req(pick_op(), pick_user(n >= 900), pick_contest(n >= 900),
                    n == 0 || n == 900);
        end
        num_items = pending_reqs.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (!(reqs_taken == num_items && outstanding == 0));
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pool_results_due.size() != 0)
            $display("%0d responses never arrived", pool_results_due.size());
        if (fail_count == 0 && pool_results_due.size() == 0)
            $display("keyed_lru_entry_pool verification clean");
        else
            $display("keyed_lru_entry_pool verification failed");
        $finish;
    end

endmodule
